FILE: rtl/pfrp_pkg.sv
package pfrp_pkg;

  localparam int unsigned FreqW = 24;
  localparam int unsigned PfdW = 19;
  localparam int unsigned PwrW = 6;
  localparam int unsigned VcoW = 34;
  localparam int unsigned FrameW = 24;
  localparam int unsigned NumW = 32;
  localparam int unsigned LadderRows = 18;

  localparam logic [FreqW-1:0] FoutMinRst = 24'd10000;
  localparam logic [FreqW-1:0] FoutMaxRst = 24'd15000000;
  localparam logic [FreqW-1:0] VcoMinRst = 24'd7500000;
  localparam logic [FreqW-1:0] VcoMaxRst = 24'd15000000;
  localparam logic [PfdW-1:0] PfdRst = 19'd100000;
  localparam logic [PwrW-1:0] PwrCapRst = 6'd31;

  localparam logic [FrameW-1:0] MashBase = 24'h2C0023;
  localparam logic [FrameW-1:0] MuxBase = 24'h2DC0DF;
  localparam logic [FrameW-1:0] R0Run = 24'h00251C;
  localparam logic [FrameW-1:0] R0Down = 24'h00251D;

  localparam logic [2:0] CfgFoutMin = 3'd0;
  localparam logic [2:0] CfgFoutMax = 3'd1;
  localparam logic [2:0] CfgVcoMin = 3'd2;
  localparam logic [2:0] CfgVcoMax = 3'd3;
  localparam logic [2:0] CfgPfd = 3'd4;
  localparam logic [2:0] CfgPwrCap = 3'd5;

  localparam logic [1:0] ReqFreq = 2'd0;
  localparam logic [1:0] ReqPower = 2'd1;
  localparam logic [1:0] ReqEnable = 2'd2;
  localparam logic [1:0] ReqPdown = 2'd3;

  // Datapath commands from the controller.
  typedef struct packed {
    logic load;      // capture request and compute the VCO
    logic div_start; // start the N / remainder division
    logic frac_start;// start the numerator division
    logic commit;    // update shadows for an accepted frequency plan
    logic single;    // update shadows for a one-frame request
  } pfrp_cmd_t;

  typedef struct packed {
    logic freq_ok;
    logic div_busy;
  } pfrp_sts_t;

  function automatic logic [FreqW-1:0] ladder_lo(input logic [4:0] i);
    logic [FreqW-1:0] v;
    unique case (i)
      5'd0: v = 24'd3750000;  5'd1: v = 24'd2000000;  5'd2: v = 24'd1300000;
      5'd3: v = 24'd940000;   5'd4: v = 24'd680000;   5'd5: v = 24'd473000;
      5'd6: v = 24'd340000;   5'd7: v = 24'd237000;   5'd8: v = 24'd168000;
      5'd9: v = 24'd138000;   5'd10: v = 24'd116000;  5'd11: v = 24'd84000;
      5'd12: v = 24'd59300;   5'd13: v = 24'd41500;   5'd14: v = 24'd29600;
      5'd15: v = 24'd20900;   5'd16: v = 24'd14800;   5'd17: v = 24'd9500;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [9:0] ladder_div(input logic [4:0] i);
    logic [9:0] v;
    unique case (i)
      5'd0: v = 10'd2;    5'd1: v = 10'd4;    5'd2: v = 10'd6;    5'd3: v = 10'd8;
      5'd4: v = 10'd12;   5'd5: v = 10'd16;   5'd6: v = 10'd24;   5'd7: v = 10'd32;
      5'd8: v = 10'd48;   5'd9: v = 10'd64;   5'd10: v = 10'd72;  5'd11: v = 10'd96;
      5'd12: v = 10'd128; 5'd13: v = 10'd192; 5'd14: v = 10'd256; 5'd15: v = 10'd384;
      5'd16: v = 10'd512; 5'd17: v = 10'd768;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/pfrp_divider.sv
// Restoring divider, one quotient bit per cycle.
module pfrp_divider #(
  parameter int unsigned DW = 64,
  parameter int unsigned VW = 19
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [VW:0] r_r, r_nxt;
  logic [VW:0] trial;
  logic [VW:0] diff;

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    r_nxt = r_r;
    trial = {r_r[VW-1:0], q_r[DW-1]};
    diff = trial - {1'b0, divisor};
    if (start) begin
      cnt_nxt = CW'(DW);
      q_nxt = dividend;
      r_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, divisor}) begin
        r_nxt = diff;
        q_nxt = {q_r[DW-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quot = q_r;
  assign rem = r_r[VW-1:0];

endmodule

FILE: rtl/pfrp_datapath.sv
module pfrp_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pfrp_pkg::pfrp_cmd_t         cmd,
  output pfrp_pkg::pfrp_sts_t         sts,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [pfrp_pkg::FreqW-1:0]  cfg_data,
  input  logic [1:0]                  in_req_type,
  input  logic [pfrp_pkg::FreqW-1:0]  in_freq_khz,
  input  logic                        in_output_sel,
  input  logic [7:0]                  in_power_level,
  input  logic                        in_switch_value,
  input  logic [3:0]                  frame_idx,
  output logic [pfrp_pkg::FrameW-1:0] frame
);

  logic [pfrp_pkg::FreqW-1:0] fmin_r, fmax_r, vmin_r, vmax_r;
  logic [pfrp_pkg::PfdW-1:0] pfd_r;
  logic [pfrp_pkg::PwrW-1:0] cap_r;
  logic [pfrp_pkg::FrameW-1:0] mash_r, mash_nxt, mux_r, mux_nxt;

  logic [1:0] req_r;
  logic sel_r, sw_r, direct_r, ok_r;
  logic [pfrp_pkg::PwrW-1:0] pwr_r;
  logic [4:0] idx_r;
  logic [pfrp_pkg::VcoW-1:0] vco_r;
  logic [18:0] n_r;
  logic [pfrp_pkg::NumW-1:0] num_r;
  logic [pfrp_pkg::FrameW-1:0] single_r;

  // Ladder search and VCO product, combinational from the input word.
  logic [4:0] idx_c;
  logic found_c, direct_c, ok_c;
  logic [9:0] div_c;
  logic [pfrp_pkg::VcoW-1:0] vco_c;
  logic [7:0] pwr_c;

  always_comb begin
    idx_c = '0;
    found_c = 1'b0;
    for (int i = pfrp_pkg::LadderRows - 1; i >= 0; i--) begin
      if (in_freq_khz >= pfrp_pkg::ladder_lo(5'(i))) begin
        idx_c = 5'(i);
        found_c = 1'b1;
      end
    end
    direct_c = (in_freq_khz >= vmin_r);
    div_c = direct_c ? 10'd1 : pfrp_pkg::ladder_div(idx_c);
    if (direct_c) idx_c = '0;
    vco_c = pfrp_pkg::VcoW'(in_freq_khz) * pfrp_pkg::VcoW'(div_c);
    ok_c = !(in_freq_khz < fmin_r || in_freq_khz > fmax_r || pfd_r == '0)
           && (direct_c || found_c)
           && !(vco_c < pfrp_pkg::VcoW'(vmin_r) || vco_c > pfrp_pkg::VcoW'(vmax_r));
    pwr_c = (in_power_level > {2'b00, cap_r}) ? {2'b00, cap_r} : in_power_level;
  end

  // One divider serves both divisions.
  logic dv_start, dv_busy;
  logic [63:0] dv_dividend, dv_quot;
  logic [pfrp_pkg::PfdW-1:0] dv_rem;
  logic frac_phase_r;

  // The numerator dividend is rem * (2^32 - 1), formed as a shift and subtract.
  assign dv_start = cmd.div_start | cmd.frac_start;
  assign dv_dividend = cmd.frac_start
                       ? ({13'd0, dv_rem, 32'd0} - {45'd0, dv_rem})
                       : 64'(vco_r);

  pfrp_divider #(.DW(64), .VW(pfrp_pkg::PfdW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dividend),
    .divisor(pfd_r), .busy(dv_busy), .quot(dv_quot), .rem(dv_rem)
  );

  always_comb begin
    mash_nxt = mash_r;
    mux_nxt = mux_r;
    if (cmd.commit) begin
      mux_nxt = {mux_r[23:13], 1'b0, direct_r, mux_r[10:0]};
      mash_nxt = {mash_r[23:3], (dv_quot[31:0] == '0) ? 3'd0 : (n_r < 19'd12) ? 3'd2 : 3'd3};
    end else if (cmd.single) begin
      unique case (req_r)
        pfrp_pkg::ReqPower: begin
          if (!sel_r) mash_nxt = {mash_r[23:14], pwr_r, mash_r[7:0]};
          else mux_nxt = {mux_r[23:6], pwr_r};
        end
        pfrp_pkg::ReqEnable: begin
          if (!sel_r) mash_nxt[6] = !sw_r;
          else mash_nxt[7] = !sw_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmin_r <= pfrp_pkg::FoutMinRst;
      fmax_r <= pfrp_pkg::FoutMaxRst;
      vmin_r <= pfrp_pkg::VcoMinRst;
      vmax_r <= pfrp_pkg::VcoMaxRst;
      pfd_r <= pfrp_pkg::PfdRst;
      cap_r <= pfrp_pkg::PwrCapRst;
      mash_r <= pfrp_pkg::MashBase;
      mux_r <= pfrp_pkg::MuxBase;
      frac_phase_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pfrp_pkg::CfgFoutMin: fmin_r <= cfg_data;
          pfrp_pkg::CfgFoutMax: fmax_r <= cfg_data;
          pfrp_pkg::CfgVcoMin: vmin_r <= cfg_data;
          pfrp_pkg::CfgVcoMax: vmax_r <= cfg_data;
          pfrp_pkg::CfgPfd: pfd_r <= cfg_data[pfrp_pkg::PfdW-1:0];
          pfrp_pkg::CfgPwrCap: cap_r <= cfg_data[pfrp_pkg::PwrW-1:0];
          default: ;
        endcase
      end
      mash_r <= mash_nxt;
      mux_r <= mux_nxt;
      if (cmd.div_start) frac_phase_r <= 1'b0;
      else if (cmd.frac_start) frac_phase_r <= 1'b1;
    end
    if (cmd.load) begin
      req_r <= in_req_type;
      sel_r <= in_output_sel;
      sw_r <= in_switch_value;
      pwr_r <= pwr_c[pfrp_pkg::PwrW-1:0];
      idx_r <= idx_c;
      direct_r <= direct_c;
      vco_r <= vco_c;
      ok_r <= ok_c;
    end
    // Capture N as the first division starts the second.
    if (cmd.frac_start) n_r <= dv_quot[18:0];
    if (frac_phase_r && !dv_busy) num_r <= dv_quot[31:0];
    if (cmd.single) begin
      unique case (req_r)
        pfrp_pkg::ReqPower: single_r <= sel_r ? mux_nxt : mash_nxt;
        pfrp_pkg::ReqEnable: single_r <= mash_nxt;
        pfrp_pkg::ReqPdown: single_r <= sw_r ? pfrp_pkg::R0Down : pfrp_pkg::R0Run;
        default: single_r <= '0;
      endcase
    end
  end

  assign sts.freq_ok = ok_r;
  assign sts.div_busy = dv_busy;

  logic [1:0] dly;
  always_comb begin
    dly = (num_r == '0) ? 2'd1 : (n_r < 19'd20) ? 2'd2 : 2'd3;
    unique case (frame_idx)
      4'd0: frame = {8'h4B, 5'b00001, idx_r, 6'd0};
      4'd1: frame = mux_r;
      4'd2: frame = 24'h26FFFF;
      4'd3: frame = 24'h27FFFF;
      4'd4: frame = {8'h2A, num_r[31:16]};
      4'd5: frame = {8'h2B, num_r[15:0]};
      4'd6: frame = {8'h22, 13'd0, n_r[18:16]};
      4'd7: frame = {8'h24, n_r[15:0]};
      4'd8: frame = mash_r;
      4'd9: frame = {8'h25, 6'd0, dly, 8'h04};
      4'd10: frame = pfrp_pkg::R0Run & ~24'd8;
      4'd11: frame = pfrp_pkg::R0Run;
      4'd12: frame = single_r;
      default: frame = '0;
    endcase
  end

endmodule

FILE: rtl/pfrp_ctrl.sv
module pfrp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_req_type,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_accepted,
  output logic                out_last,
  output logic [3:0]          frame_idx,
  output pfrp_pkg::pfrp_cmd_t cmd,
  input  pfrp_pkg::pfrp_sts_t sts
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_DIVN = 7'b0000100,
    S_DIVF = 7'b0001000,
    S_EMIT = 7'b0010000,
    S_ONE = 7'b0100000,
    S_REJ = 7'b1000000
  } state_t;

  state_t st_r, st_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic wait_r, wait_nxt;
  logic take, out_take;

  assign in_stall = (st_r != S_IDLE);
  assign take = in_valid && (st_r == S_IDLE);
  assign out_take = out_valid && !out_stall;

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    wait_nxt = 1'b0;
    cmd = '0;
    cmd.load = take;
    unique case (st_r)
      S_IDLE: begin
        if (take) begin
          if (in_req_type == pfrp_pkg::ReqFreq) st_nxt = S_CHECK;
          else begin
            st_nxt = S_ONE;
            wait_nxt = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (sts.freq_ok) begin
          cmd.div_start = 1'b1;
          st_nxt = S_DIVN;
          wait_nxt = 1'b1;
        end else st_nxt = S_REJ;
      end
      S_DIVN: begin
        if (!wait_r && !sts.div_busy) begin
          cmd.frac_start = 1'b1;
          st_nxt = S_DIVF;
          wait_nxt = 1'b1;
        end
      end
      S_DIVF: begin
        // The numerator is captured in the cycle the divider goes idle.
        if (!wait_r && !sts.div_busy) begin
          cmd.commit = 1'b1;
          st_nxt = S_EMIT;
          idx_nxt = '0;
        end
      end
      S_EMIT: begin
        if (out_take) begin
          if (idx_r == 4'd11) st_nxt = S_IDLE;
          else idx_nxt = idx_r + 1'b1;
        end
      end
      S_ONE: begin
        if (wait_r) cmd.single = 1'b1;
        else if (out_take) st_nxt = S_IDLE;
      end
      S_REJ: begin
        if (out_take) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      idx_r <= '0;
      wait_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      wait_r <= wait_nxt;
    end
  end

  assign out_valid = (st_r == S_EMIT) || (st_r == S_REJ) || (st_r == S_ONE && !wait_r);
  assign out_accepted = (st_r != S_REJ);
  assign out_last = (st_r != S_EMIT) || (idx_r == 4'd11);
  assign frame_idx = (st_r == S_ONE) ? 4'd12 : (st_r == S_REJ) ? 4'd13 : idx_r;

endmodule

FILE: rtl/pll_frequency_register_planner.sv
// Frequency planner for a fractional-N PLL: each request word turns into
// the 24-bit register write words that carry it out.
// The input channel (in_valid / in_stall) takes one request word at a time;
// in_stall stays high from acceptance until the last result word of that
// request has been taken. The result channel (out_valid / out_stall) then
// gives one word per cycle while the receiver does not stall; a stalled
// word holds steady.
// A set-frequency request is first checked against the ranges and given a
// ladder row, then runs two passes of a shared one-bit-per-cycle divider
// (N and remainder, then numerator) before its first result. Twelve words
// follow. A rejected request gives one empty word with accepted low. Power,
// enable and powerdown requests give one word. Configuration is written
// through cfg_we / cfg_index / cfg_data by the user, only while idle; the
// block does not enforce it. Reset restores register defaults and shadows.
module pll_frequency_register_planner (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [pfrp_pkg::FreqW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [pfrp_pkg::FreqW-1:0]  in_freq_khz,
  input  logic                        in_output_sel,
  input  logic [7:0]                  in_power_level,
  input  logic                        in_switch_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pfrp_pkg::FrameW-1:0] out_frame,
  output logic                        out_frame_valid,
  output logic                        out_accepted,
  output logic                        out_last
);

  pfrp_pkg::pfrp_cmd_t cmd;
  pfrp_pkg::pfrp_sts_t sts;
  logic [3:0] frame_idx;

  pfrp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .out_valid(out_valid), .out_stall(out_stall),
    .out_accepted(out_accepted), .out_last(out_last), .frame_idx(frame_idx),
    .cmd(cmd), .sts(sts)
  );

  pfrp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .in_req_type(in_req_type),
    .in_freq_khz(in_freq_khz), .in_output_sel(in_output_sel),
    .in_power_level(in_power_level), .in_switch_value(in_switch_value),
    .frame_idx(frame_idx), .frame(out_frame)
  );

  // An empty word (rejection) is the only one without a write to send.
  assign out_frame_valid = out_accepted;

endmodule

FILE: tb/pll_frequency_register_planner_test.sv
`timescale 1ns / 100ps

module pll_frequency_register_planner_test;

  // One request word as offered on the input channel.
  typedef struct {
    logic [1:0]                 req;
    logic [pfrp_pkg::FreqW-1:0] freq;
    logic                       sel;
    logic [7:0]                 pwr;
    logic                       sw;
  } request_t;

  // One result word as seen on the output channel.
  typedef struct {
    logic [pfrp_pkg::FrameW-1:0] frame;
    logic                        fvalid;
    logic                        acc;
    logic                        last;
  } frame_word_t;

  localparam int unsigned WatchLimit = 40000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [pfrp_pkg::FreqW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_req_type;
  logic [pfrp_pkg::FreqW-1:0] in_freq_khz;
  logic in_output_sel;
  logic [7:0] in_power_level;
  logic in_switch_value;
  logic out_valid;
  logic out_stall;
  logic [pfrp_pkg::FrameW-1:0] out_frame;
  logic out_frame_valid;
  logic out_accepted;
  logic out_last;

  pll_frequency_register_planner u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_freq_khz(in_freq_khz),
    .in_output_sel(in_output_sel), .in_power_level(in_power_level),
    .in_switch_value(in_switch_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_frame(out_frame), .out_frame_valid(out_frame_valid),
    .out_accepted(out_accepted), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Planner copy of the configuration and the two shadow registers.
  logic [pfrp_pkg::FreqW-1:0] plan_fout_min, plan_fout_max, plan_vco_min, plan_vco_max;
  logic [pfrp_pkg::PfdW-1:0]  plan_pfd;
  logic [pfrp_pkg::PwrW-1:0]  plan_pwr_cap;
  logic [pfrp_pkg::FrameW-1:0] mash_shadow, mux_shadow;

  request_t    pending_reqs[$];
  frame_word_t expected_frames[$];

  int  send_idle_pct;   // percent of cycles the sender holds back
  int  recv_idle_pct;   // percent of cycles the receiver stalls
  int  hold_off_cycles; // long receiver stall requested by the stimulus
  bit  failed;
  int  quiet_cycles;

  function automatic logic [pfrp_pkg::FreqW-1:0] ladder_floor(int i);
    logic [pfrp_pkg::FreqW-1:0] t[18] = '{24'd3750000, 24'd2000000, 24'd1300000,
      24'd940000, 24'd680000, 24'd473000, 24'd340000, 24'd237000, 24'd168000,
      24'd138000, 24'd116000, 24'd84000, 24'd59300, 24'd41500, 24'd29600,
      24'd20900, 24'd14800, 24'd9500};
    return t[i];
  endfunction

  function automatic int ladder_ratio(int i);
    int t[18] = '{2, 4, 6, 8, 12, 16, 24, 32, 48, 64, 72, 96, 128, 192, 256, 384,
      512, 768};
    return t[i];
  endfunction

  function automatic void push_frame(logic [pfrp_pkg::FrameW-1:0] f, logic v, logic a,
                                     logic l);
    frame_word_t w;
    w.frame = f;
    w.fvalid = v;
    w.acc = a;
    w.last = l;
    expected_frames.push_back(w);
  endfunction

  // Works out the frequency plan: divider choice, N, numerator, MASH order.
  function automatic void plan_frequency(logic [pfrp_pkg::FreqW-1:0] f);
    int unsigned ratio, row;
    bit direct;
    logic [63:0] vco, rem, num64;
    logic [18:0] n;
    logic [31:0] num;
    logic [2:0] mash;
    logic [5:0] dly;
    logic [pfrp_pkg::FrameW-1:0] words[12];
    ratio = 0;
    row = 0;
    if (f < plan_fout_min || f > plan_fout_max || plan_pfd == 0) begin
      push_frame('0, 1'b0, 1'b0, 1'b1);
      return;
    end
    direct = (f >= plan_vco_min);
    if (direct) ratio = 1;
    else begin
      for (int i = 0; i < 18; i++) begin
        if (ratio == 0 && f >= ladder_floor(i)) begin
          ratio = ladder_ratio(i);
          row = i;
        end
      end
      if (ratio == 0) begin
        push_frame('0, 1'b0, 1'b0, 1'b1);
        return;
      end
    end
    vco = 64'(f) * 64'(ratio);
    if (vco < 64'(plan_vco_min) || vco > 64'(plan_vco_max)) begin
      push_frame('0, 1'b0, 1'b0, 1'b1);
      return;
    end
    n = 19'(vco / 64'(plan_pfd));
    rem = vco % 64'(plan_pfd);
    num64 = (rem * 64'hFFFF_FFFF) / 64'(plan_pfd);
    num = num64[31:0];
    if (num == 0) begin mash = 3'd0; dly = 6'd1; end
    else if (n < 12) begin mash = 3'd2; dly = 6'd2; end
    else if (n < 20) begin mash = 3'd3; dly = 6'd2; end
    else begin mash = 3'd3; dly = 6'd3; end
    mux_shadow[12:11] = {1'b0, direct};
    mash_shadow[2:0] = mash;
    words[0] = 24'h4B0000 | (24'h0800 & ~24'h07C0) | (24'(row) << 6);
    words[1] = mux_shadow;
    words[2] = 24'h26FFFF;
    words[3] = 24'h27FFFF;
    words[4] = 24'h2A0000 | 24'(num[31:16]);
    words[5] = 24'h2B0000 | 24'(num[15:0]);
    words[6] = 24'h220000 | 24'(n[18:16]);
    words[7] = 24'h240000 | 24'(n[15:0]);
    words[8] = mash_shadow;
    words[9] = 24'h250000 | (24'h0304 & ~24'h3F00) | (24'(dly) << 8);
    words[10] = pfrp_pkg::R0Run & ~24'h8;
    words[11] = pfrp_pkg::R0Run;
    for (int i = 0; i < 12; i++) push_frame(words[i], 1'b1, 1'b1, i == 11);
  endfunction

  function automatic void plan_request(request_t r);
    logic [7:0] p;
    logic [pfrp_pkg::FrameW-1:0] f;
    case (r.req)
      pfrp_pkg::ReqFreq: begin
        plan_frequency(r.freq);
        return;
      end
      pfrp_pkg::ReqPower: begin
        p = (r.pwr > 8'(plan_pwr_cap)) ? 8'(plan_pwr_cap) : r.pwr;
        if (!r.sel) begin
          mash_shadow[13:8] = p[5:0];
          f = mash_shadow;
        end else begin
          mux_shadow[5:0] = p[5:0];
          f = mux_shadow;
        end
      end
      pfrp_pkg::ReqEnable: begin
        // Enable clears the output's powerdown bit; disable sets it.
        mash_shadow[r.sel ? 7 : 6] = ~r.sw;
        f = mash_shadow;
      end
      default: f = r.sw ? pfrp_pkg::R0Down : pfrp_pkg::R0Run;
    endcase
    push_frame(f, 1'b1, 1'b1, 1'b1);
  endfunction

  // The driver runs on the falling edge, so it needs to know whether the word
  // it held was taken at the preceding rising edge.
  logic in_stall_q;
  always @(posedge clk) in_stall_q <= in_stall;

  // Driver: offers the oldest pending word; inputs change on the falling edge.
  always @(negedge clk) begin
    bit sent;
    sent = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall_q) begin
        plan_request(pending_reqs.pop_front());
        sent = 1'b1;
      end
      if ((!in_valid || sent) && pending_reqs.size() > 0
          && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_req_type <= pending_reqs[0].req;
        in_freq_khz <= pending_reqs[0].freq;
        in_output_sel <= pending_reqs[0].sel;
        in_power_level <= pending_reqs[0].pwr;
        in_switch_value <= pending_reqs[0].sw;
      end else if (sent) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, including the long hold-off stretch.
  int hold_count;
  always @(negedge clk) begin
    if (hold_off_cycles > 0 && hold_count == 0) begin
      hold_count <= hold_off_cycles;
      hold_off_cycles <= 0;
      out_stall <= 1'b1;
    end else if (hold_count > 1) begin
      hold_count <= hold_count - 1;
      out_stall <= 1'b1;
    end else begin
      hold_count <= 0;
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: compares each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    frame_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("result word with nothing expected: frame %h", out_frame);
        failed = 1'b1;
      end else begin
        w = expected_frames.pop_front();
        if (out_frame !== w.frame) begin
          $error("frame: expected %h actual %h", w.frame, out_frame);
          failed = 1'b1;
        end
        if (out_frame_valid !== w.fvalid) begin
          $error("frame_valid: expected %b actual %b", w.fvalid, out_frame_valid);
          failed = 1'b1;
        end
        if (out_accepted !== w.acc) begin
          $error("accepted: expected %b actual %b", w.acc, out_accepted);
          failed = 1'b1;
        end
        if (out_last !== w.last) begin
          $error("last: expected %b actual %b", w.last, out_last);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [pfrp_pkg::FreqW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pfrp_pkg::CfgFoutMin: plan_fout_min = val;
      pfrp_pkg::CfgFoutMax: plan_fout_max = val;
      pfrp_pkg::CfgVcoMin: plan_vco_min = val;
      pfrp_pkg::CfgVcoMax: plan_vco_max = val;
      pfrp_pkg::CfgPfd: plan_pfd = val[pfrp_pkg::PfdW-1:0];
      default: plan_pwr_cap = val[pfrp_pkg::PwrW-1:0];
    endcase
  endtask

  task automatic queue_req(logic [1:0] t, logic [pfrp_pkg::FreqW-1:0] f, logic s,
                           logic [7:0] p, logic w);
    request_t r;
    r.req = t;
    r.freq = f;
    r.sel = s;
    r.pwr = p;
    r.sw = w;
    pending_reqs.push_back(r);
  endtask

  // Waits for everything queued to be sent and answered, then lets the
  // block settle before any register write.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_frames.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly in-range frequencies, spread over the ladder rows and the VCO range.
  function automatic logic [pfrp_pkg::FreqW-1:0] pick_freq();
    int k;
    k = $urandom_range(99);
    if (k < 10) return pfrp_pkg::FreqW'($urandom);
    if (k < 40) return pfrp_pkg::FreqW'($urandom_range(15000000, 7500000));
    if (k < 50) begin
      return ladder_floor($urandom_range(17)) + pfrp_pkg::FreqW'($urandom_range(3));
    end
    if (k < 55) return pfrp_pkg::FreqW'($urandom_range(9600, 0));
    return pfrp_pkg::FreqW'($urandom_range(7499999, 9500));
  endfunction

  task automatic queue_random(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 55) begin
        queue_req(pfrp_pkg::ReqFreq, pick_freq(), 1'($urandom), 8'($urandom),
                  1'($urandom));
      end else begin
        queue_req(2'($urandom_range(3, 1)), pfrp_pkg::FreqW'($urandom), 1'($urandom),
                  8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    failed = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pfrp_pkg::CfgFoutMin;
    cfg_data = '0;
    in_valid = 1'b0;
    in_req_type = pfrp_pkg::ReqFreq;
    in_freq_khz = '0;
    in_output_sel = 1'b0;
    in_power_level = '0;
    in_switch_value = 1'b0;
    out_stall = 1'b0;
    hold_count = 0;
    hold_off_cycles = 0;
    quiet_cycles = 0;
    send_idle_pct = 27;
    recv_idle_pct = 70;
    plan_fout_min = pfrp_pkg::FoutMinRst;
    plan_fout_max = pfrp_pkg::FoutMaxRst;
    plan_vco_min = pfrp_pkg::VcoMinRst;
    plan_vco_max = pfrp_pkg::VcoMaxRst;
    plan_pfd = pfrp_pkg::PfdRst;
    plan_pwr_cap = pfrp_pkg::PwrCapRst;
    mash_shadow = pfrp_pkg::MashBase;
    mux_shadow = pfrp_pkg::MuxBase;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words at reset settings: range edges, the direct path, integer
    // and fractional plans, ladder edges, and every one-frame request kind.
    queue_req(pfrp_pkg::ReqFreq, 24'd10000, 1'b0, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqFreq, 24'd15000000, 1'b0, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqFreq, 24'd15000001, 1'b0, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqFreq, 24'd9999, 1'b0, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqFreq, 24'hFFFFFF, 1'b1, 8'hFF, 1'b1);
    queue_req(pfrp_pkg::ReqFreq, 24'd7500000, 1'b0, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqFreq, 24'd7499999, 1'b0, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqFreq, 24'd3750000, 1'b0, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqFreq, 24'd9500, 1'b0, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqFreq, 24'd1234567, 1'b0, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqPower, 24'd0, 1'b0, 8'd255, 1'b0);
    queue_req(pfrp_pkg::ReqPower, 24'd0, 1'b1, 8'd7, 1'b1);
    queue_req(pfrp_pkg::ReqPower, 24'd0, 1'b1, 8'd31, 1'b0);
    queue_req(pfrp_pkg::ReqEnable, 24'd0, 1'b0, 8'd0, 1'b1);
    queue_req(pfrp_pkg::ReqEnable, 24'd0, 1'b1, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqEnable, 24'd0, 1'b1, 8'd0, 1'b1);
    queue_req(pfrp_pkg::ReqPdown, 24'd0, 1'b0, 8'd0, 1'b1);
    queue_req(pfrp_pkg::ReqPdown, 24'hFFFFFF, 1'b1, 8'hFF, 1'b0);
    drain();

    // Large phase detector: low N, with fractional and integer plans; a cap of zero.
    write_reg(pfrp_pkg::CfgPfd, 24'd400000);
    write_reg(pfrp_pkg::CfgPwrCap, 24'd0);
    queue_req(pfrp_pkg::ReqFreq, 24'd7600001, 1'b0, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqFreq, 24'd14800000, 1'b0, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqPower, 24'd0, 1'b0, 8'd9, 1'b0);
    queue_random(60);
    drain();

    // Low phase detector and full power range, wide-open limits.
    write_reg(pfrp_pkg::CfgPfd, 24'd125);
    write_reg(pfrp_pkg::CfgPwrCap, 24'd63);
    write_reg(pfrp_pkg::CfgFoutMin, 24'd0);
    write_reg(pfrp_pkg::CfgFoutMax, 24'hFFFFFF);
    write_reg(pfrp_pkg::CfgVcoMin, 24'd0);
    write_reg(pfrp_pkg::CfgVcoMax, 24'hFFFFFF);
    queue_req(pfrp_pkg::ReqFreq, 24'd0, 1'b0, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqFreq, 24'hFFFFFF, 1'b0, 8'd0, 1'b0);
    queue_req(pfrp_pkg::ReqPower, 24'd0, 1'b1, 8'd63, 1'b0);
    queue_random(60);
    drain();

    // Inverted ranges reject every frequency request; PFD field kept at 19 bits.
    write_reg(pfrp_pkg::CfgFoutMin, 24'd9000000);
    write_reg(pfrp_pkg::CfgFoutMax, 24'd1000);
    write_reg(pfrp_pkg::CfgPfd, 24'hFFFFFF);
    queue_random(20);
    drain();

    // Back to the reset limits with a 61440 PFD; the sender now idles more.
    write_reg(pfrp_pkg::CfgFoutMin, pfrp_pkg::FoutMinRst);
    write_reg(pfrp_pkg::CfgFoutMax, pfrp_pkg::FoutMaxRst);
    write_reg(pfrp_pkg::CfgVcoMin, pfrp_pkg::VcoMinRst);
    write_reg(pfrp_pkg::CfgVcoMax, pfrp_pkg::VcoMaxRst);
    write_reg(pfrp_pkg::CfgPfd, 24'd61440);
    write_reg(pfrp_pkg::CfgPwrCap, 24'(pfrp_pkg::PwrCapRst));
    send_idle_pct = 70;
    recv_idle_pct = 27;
    queue_random(100);
    drain();

    // Long receiver hold-off while the sender keeps offering words.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(pfrp_pkg::CfgPfd, 24'(pfrp_pkg::PfdRst));
    queue_random(20);
    hold_off_cycles = 600;
    drain();

    queue_random(140);
    drain();

    if (!failed && expected_frames.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
